/* hdl/tsc_pkg.sv */
package tsc_pkg;

  localparam int TERMS_DEF     = 12;
  localparam int OUT_FRAC_BITS = 30;

  localparam int ANGLE_W    = 32;
  localparam int OUT_W      = 32;
  localparam int ANGLE_FRAC = 27;
  localparam int WORD_W     = 64;
  localparam int MAG_W      = 63;
  localparam int PROD_W     = 128;
  localparam int HALF_W     = 32;
  localparam int WFRAC      = 56;
  localparam int RED_STAGES = 3;

  localparam logic signed [WORD_W-1:0] PI_Q56     = 64'sh0324_3F6A_8885_A309;
  localparam logic signed [WORD_W-1:0] TWO_PI_Q56 = 64'sh0648_7ED5_110B_4612;
  localparam logic signed [WORD_W-1:0] ONE_Q56    = 64'sh0100_0000_0000_0000;

  typedef struct packed {
    logic                     valid;
    logic [MAG_W-1:0]         x2;
    logic signed [WORD_W-1:0] ts;
    logic signed [WORD_W-1:0] tc;
    logic signed [WORD_W-1:0] ss;
    logic signed [WORD_W-1:0] sc;
  } lane_t;

  function automatic logic [WORD_W-1:0] mag64(input logic signed [WORD_W-1:0] v);
    logic [WORD_W-1:0] u;
    u = v;
    return v[WORD_W-1] ? (~u + 64'd1) : u;
  endfunction

  // q56 product back to q56, round half away from zero on the magnitude
  function automatic logic [MAG_W-1:0] round_q56(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] t;
    t = p + (128'd1 << (WFRAC - 1));
    return t[WFRAC +: MAG_W];
  endfunction

endpackage

/* hdl/taylor_sine_cosine_top.sv */
// Sine and cosine of a signed Q5.27 angle in radians, returned as signed Q2.30 values
// clamped to [-1.0, +1.0]. The angle is widened to Q56, folded into [-pi, pi] by up to
// three steps of 2*pi, squared, and then runs through TERMS-1 term cells; each cell adds
// its terms into the sums and forms the next sine and cosine terms with a 64-bit multiply
// and a constant divide done as a reciprocal multiply, six stages in all. A request is
// taken in every cycle (start while busy is low); busy is high only during reset and the
// first cycle after it. The result passes the widening and fold stages, the squaring, the
// term cells and two output registers, and is shown for exactly one cycle with out_valid
// high. Results leave in request order and cannot be held off, so the receiver must take
// every strobe. There are no configuration registers.
module taylor_sine_cosine_top #(
  parameter int TERMS = tsc_pkg::TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tsc_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_valid,
  output logic signed [tsc_pkg::OUT_W-1:0]    out_sine,
  output logic signed [tsc_pkg::OUT_W-1:0]    out_cosine
);

  localparam int W   = tsc_pkg::WORD_W;
  localparam int RS  = tsc_pkg::RED_STAGES;
  localparam int SQ  = 3;
  localparam int SH  = tsc_pkg::WFRAC - tsc_pkg::OUT_FRAC_BITS;
  localparam int PAD = tsc_pkg::WFRAC - tsc_pkg::ANGLE_FRAC;
  localparam int EXT = W - tsc_pkg::ANGLE_W - PAD;
  localparam logic [W-1:0] LIM  = 64'd1 << tsc_pkg::OUT_FRAC_BITS;
  localparam logic [W-1:0] HALF = 64'd1 << (SH - 1);

  logic                  busy_r;
  logic                  accept;
  logic signed [W-1:0]   stg_r [RS+1];
  logic [RS:0]           stg_v_r;
  logic signed [W-1:0]   xd_r [SQ];
  logic [SQ-1:0]         sq_v_r;
  logic [W-1:0]          mag_x;
  logic [tsc_pkg::PROD_W-1:0] sq_prod;
  logic [tsc_pkg::MAG_W-1:0]  x2_r;
  tsc_pkg::lane_t        lane [TERMS];
  logic                  fv_r;
  logic signed [W-1:0]   fs_r;
  logic signed [W-1:0]   fc_r;
  logic                  out_valid_r;
  logic signed [tsc_pkg::OUT_W-1:0] out_sine_r;
  logic signed [tsc_pkg::OUT_W-1:0] out_cosine_r;

  function automatic logic signed [W-1:0] fold(input logic signed [W-1:0] x);
    logic signed [W-1:0] r;
    r = x;
    if (x > tsc_pkg::PI_Q56) begin
      r = x - tsc_pkg::TWO_PI_Q56;
    end else if (x < -tsc_pkg::PI_Q56) begin
      r = x + tsc_pkg::TWO_PI_Q56;
    end
    return r;
  endfunction

  function automatic logic signed [tsc_pkg::OUT_W-1:0] to_out(input logic signed [W-1:0] s);
    logic [W-1:0]             m;
    logic [W-1:0]             q;
    logic [tsc_pkg::OUT_W-1:0] r;
    m = tsc_pkg::mag64(s);
    q = (m + HALF) >> SH;
    if (q > LIM) begin
      q = LIM;
    end
    r = q[tsc_pkg::OUT_W-1:0];
    return s[W-1] ? -r : r;
  endfunction

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      stg_v_r     <= '0;
      sq_v_r      <= '0;
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      stg_v_r     <= {stg_v_r[RS-1:0], accept};
      sq_v_r      <= {sq_v_r[SQ-2:0], stg_v_r[RS]};
      fv_r        <= lane[TERMS-1].valid;
      out_valid_r <= fv_r;
    end
  end

  // widen to q56, then one 2*pi step per stage
  always_ff @(posedge clk) begin
    stg_r[0] <= {{EXT{in_angle[tsc_pkg::ANGLE_W-1]}}, in_angle, {PAD{1'b0}}};
    for (int i = 1; i <= RS; i++) begin
      stg_r[i] <= fold(stg_r[i-1]);
    end
  end

  assign mag_x = tsc_pkg::mag64(stg_r[RS]);

  tsc_mul u_mul_sq (.clk(clk), .a(mag_x), .b(mag_x), .p(sq_prod));

  always_ff @(posedge clk) begin
    xd_r[0] <= stg_r[RS];
    for (int i = 1; i < SQ; i++) begin
      xd_r[i] <= xd_r[i-1];
    end
    x2_r <= tsc_pkg::round_q56(sq_prod);
  end

  always_comb begin
    lane[0].valid = sq_v_r[SQ-1];
    lane[0].x2    = x2_r;
    lane[0].ts    = xd_r[SQ-1];
    lane[0].tc    = tsc_pkg::ONE_Q56;
    lane[0].ss    = '0;
    lane[0].sc    = '0;
  end

  for (genvar g = 0; g < TERMS - 1; g++) begin : g_cell
    tsc_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_lane  (lane[g]),
      .out_lane (lane[g+1])
    );
  end

  // last terms go in without forming further ones
  always_ff @(posedge clk) begin
    fs_r         <= lane[TERMS-1].ss + lane[TERMS-1].ts;
    fc_r         <= lane[TERMS-1].sc + lane[TERMS-1].tc;
    out_sine_r   <= to_out(fs_r);
    out_cosine_r <= to_out(fc_r);
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = out_sine_r;
  assign out_cosine = out_cosine_r;

endmodule

/* hdl/tsc_mul.sv */
module tsc_mul (
  input  logic                          clk,
  input  logic [tsc_pkg::WORD_W-1:0]    a,
  input  logic [tsc_pkg::WORD_W-1:0]    b,
  output logic [tsc_pkg::PROD_W-1:0]    p
);

  localparam int H = tsc_pkg::HALF_W;

  logic [tsc_pkg::WORD_W-1:0] ll_r;
  logic [tsc_pkg::WORD_W-1:0] lh_r;
  logic [tsc_pkg::WORD_W-1:0] hl_r;
  logic [tsc_pkg::WORD_W-1:0] hh_r;
  logic [tsc_pkg::PROD_W-1:0] p_r;

  // four 32x32 partial products, then one registered sum
  always_ff @(posedge clk) begin
    ll_r <= 64'(a[H-1:0]) * 64'(b[H-1:0]);
    lh_r <= 64'(a[H-1:0]) * 64'(b[2*H-1:H]);
    hl_r <= 64'(a[2*H-1:H]) * 64'(b[H-1:0]);
    hh_r <= 64'(a[2*H-1:H]) * 64'(b[2*H-1:H]);
    p_r  <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {hh_r, 64'd0};
  end

  assign p = p_r;

endmodule

/* hdl/tsc_cell.sv */
module tsc_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tsc_pkg::lane_t in_lane,
  output tsc_pkg::lane_t out_lane
);

  localparam int DEPTH = 6;
  localparam int DS    = (2 * IDX + 2) * (2 * IDX + 3);
  localparam int DC    = (2 * IDX + 1) * (2 * IDX + 2);
  localparam int KS    = tsc_pkg::MAG_W + $clog2(DS);
  localparam int KC    = tsc_pkg::MAG_W + $clog2(DC);
  localparam logic [127:0] RS_W = ((128'd1 << KS) + 128'(DS) - 128'd1) / 128'(DS);
  localparam logic [127:0] RC_W = ((128'd1 << KC) + 128'(DC) - 128'd1) / 128'(DC);
  localparam logic [63:0]  RECIP_S = RS_W[63:0];
  localparam logic [63:0]  RECIP_C = RC_W[63:0];

  typedef struct packed {
    logic [tsc_pkg::MAG_W-1:0]         x2;
    logic signed [tsc_pkg::WORD_W-1:0] ss;
    logic signed [tsc_pkg::WORD_W-1:0] sc;
    logic                              ns;
    logic                              nc;
  } side_t;

  side_t                             side_r [DEPTH];
  side_t                             side_nxt;
  logic [DEPTH-1:0]                  v_r;
  logic [tsc_pkg::WORD_W-1:0]        mag_ts;
  logic [tsc_pkg::WORD_W-1:0]        mag_tc;
  logic [tsc_pkg::PROD_W-1:0]        ps_prod;
  logic [tsc_pkg::PROD_W-1:0]        pc_prod;
  logic [tsc_pkg::PROD_W-1:0]        qs_prod;
  logic [tsc_pkg::PROD_W-1:0]        qc_prod;
  logic [tsc_pkg::MAG_W-1:0]         rs_r;
  logic [tsc_pkg::MAG_W-1:0]         rc_r;
  logic [tsc_pkg::MAG_W-1:0]         qs;
  logic [tsc_pkg::MAG_W-1:0]         qc;
  logic signed [tsc_pkg::WORD_W-1:0] qs_ext;
  logic signed [tsc_pkg::WORD_W-1:0] qc_ext;
  logic signed [tsc_pkg::WORD_W-1:0] ts_r;
  logic signed [tsc_pkg::WORD_W-1:0] tc_r;
  logic signed [tsc_pkg::WORD_W-1:0] ts_nxt;
  logic signed [tsc_pkg::WORD_W-1:0] tc_nxt;

  assign mag_ts = tsc_pkg::mag64(in_lane.ts);
  assign mag_tc = tsc_pkg::mag64(in_lane.tc);

  always_comb begin
    side_nxt.x2 = in_lane.x2;
    side_nxt.ss = in_lane.ss + in_lane.ts;
    side_nxt.sc = in_lane.sc + in_lane.tc;
    side_nxt.ns = in_lane.ts[tsc_pkg::WORD_W-1];
    side_nxt.nc = in_lane.tc[tsc_pkg::WORD_W-1];
  end

  // term times x squared
  tsc_mul u_mul_s (.clk(clk), .a(mag_ts), .b({1'b0, in_lane.x2}), .p(ps_prod));
  tsc_mul u_mul_c (.clk(clk), .a(mag_tc), .b({1'b0, in_lane.x2}), .p(pc_prod));

  // divide by the constant through its reciprocal
  tsc_mul u_div_s (.clk(clk), .a({1'b0, rs_r}), .b(RECIP_S), .p(qs_prod));
  tsc_mul u_div_c (.clk(clk), .a({1'b0, rc_r}), .b(RECIP_C), .p(qc_prod));

  always_comb begin
    qs     = 63'(qs_prod >> KS);
    qc     = 63'(qc_prod >> KC);
    qs_ext = {1'b0, qs};
    qc_ext = {1'b0, qc};
    // next term carries the opposite sign
    ts_nxt = side_r[DEPTH-2].ns ? qs_ext : -qs_ext;
    tc_nxt = side_r[DEPTH-2].nc ? qc_ext : -qc_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DEPTH-2:0], in_lane.valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int i = 1; i < DEPTH; i++) begin
      side_r[i] <= side_r[i-1];
    end
    rs_r <= tsc_pkg::round_q56(ps_prod);
    rc_r <= tsc_pkg::round_q56(pc_prod);
    ts_r <= ts_nxt;
    tc_r <= tc_nxt;
  end

  always_comb begin
    out_lane.valid = v_r[DEPTH-1];
    out_lane.x2    = side_r[DEPTH-1].x2;
    out_lane.ts    = ts_r;
    out_lane.tc    = tc_r;
    out_lane.ss    = side_r[DEPTH-1].ss;
    out_lane.sc    = side_r[DEPTH-1].sc;
  end

endmodule

/* hdl/tsc_checker.sv */
module tsc_checker #(
  parameter int TERMS = tsc_pkg::TERMS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [tsc_pkg::ANGLE_W-1:0] in_angle,
  input logic                               out_valid,
  input logic signed [tsc_pkg::OUT_W-1:0]   out_sine,
  input logic signed [tsc_pkg::OUT_W-1:0]   out_cosine
);

  localparam int LAT = 6 * TERMS + 3;
  localparam logic signed [tsc_pkg::OUT_W-1:0] ONE_OUT = 32'sd1 <<< tsc_pkg::OUT_FRAC_BITS;

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset recovery");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing at fixed latency");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine <= ONE_OUT && out_sine >= -ONE_OUT &&
                   out_cosine <= ONE_OUT && out_cosine >= -ONE_OUT))
    else $error("result outside unit range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_angle == 32'sd0) |->
      ##LAT (out_sine == 32'sd0 && out_cosine == ONE_OUT))
    else $error("zero angle gave wrong result");

endmodule

bind taylor_sine_cosine_top tsc_checker #(.TERMS(TERMS)) u_tsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_angle   (in_angle),
  .out_valid  (out_valid),
  .out_sine   (out_sine),
  .out_cosine (out_cosine)
);

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERMS_TB  = tsc_pkg::TERMS_DEF;
  localparam int LATENCY   = 6 * TERMS_TB + 3;
  localparam int Q56_FRAC  = 56;
  localparam int ROUND_SH  = Q56_FRAC - tsc_pkg::OUT_FRAC_BITS;
  localparam longint HALF_TURN = 64'sh0324_3F6A_8885_A309;
  localparam longint UNIT_Q56  = 64'sh0100_0000_0000_0000;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } sincos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [tsc_pkg::ANGLE_W-1:0] in_angle = '0;
  logic busy;
  logic out_valid;
  logic signed [tsc_pkg::OUT_W-1:0] out_sine;
  logic signed [tsc_pkg::OUT_W-1:0] out_cosine;

  sincos_t expected_sincos[$];
  int mismatch_count = 0;
  int results_seen = 0;
  int angles_sent = 0;

  taylor_sine_cosine_top #(.TERMS(TERMS_TB)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_angle(in_angle),
    .out_valid(out_valid),
    .out_sine(out_sine),
    .out_cosine(out_cosine)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] q56_mag(longint v);
    logic [63:0] u;
    u = v;
    return (v < 0) ? -u : u;
  endfunction

  // magnitude product, round half away from zero, keep 63 bits
  function automatic longint q56_mul(longint a, longint b);
    logic [127:0] p;
    longint r;
    p = {64'd0, q56_mag(a)} * {64'd0, q56_mag(b)};
    p = p + (128'd1 << (Q56_FRAC - 1));
    r = longint'({1'b0, p[Q56_FRAC +: 63]});
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic [31:0] q56_to_out(longint s);
    logic [63:0] m;
    logic [63:0] q;
    m = q56_mag(s);
    q = (m + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    if (q > (64'd1 << tsc_pkg::OUT_FRAC_BITS))
      q = 64'd1 << tsc_pkg::OUT_FRAC_BITS;
    if (s < 0)
      q = -q;
    return q[31:0];
  endfunction

  function automatic sincos_t predict_sincos(logic signed [31:0] angle);
    longint x, x2, ts, tc, ss, sc, ds, dc;
    sincos_t r;
    x = longint'(angle) * (longint'(1) << (Q56_FRAC - tsc_pkg::ANGLE_FRAC));
    while (x > HALF_TURN)
      x -= 2 * HALF_TURN;
    while (x < -HALF_TURN)
      x += 2 * HALF_TURN;
    x2 = q56_mul(x, x);
    ts = x;
    tc = UNIT_Q56;
    ss = 0;
    sc = 0;
    for (int n = 0; n < TERMS_TB; n++) begin
      ds = longint'((2 * n + 2) * (2 * n + 3));
      dc = longint'((2 * n + 1) * (2 * n + 2));
      ss += ts;
      sc += tc;
      ts = -(q56_mul(ts, x2) / ds);
      tc = -(q56_mul(tc, x2) / dc);
    end
    r.angle = angle;
    r.sine = q56_to_out(ss);
    r.cosine = q56_to_out(sc);
    return r;
  endfunction

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // request held until taken; start stays high for a following request
  task automatic send_angle(logic signed [31:0] angle);
    start <= 1'b1;
    in_angle <= angle;
    do @(posedge clk); while (busy !== 1'b0);
    expected_sincos.push_back(predict_sincos(angle));
    angles_sent++;
  endtask

  task automatic pause_requests(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // random run of idle cycles; each draw under 27 in 100 lengthens it, so start is low about 27 percent of the time
  task automatic maybe_pause();
    while ($urandom_range(0, 99) < 27)
      pause_requests(1);
  endtask

  function automatic logic signed [31:0] near_pi_multiple(int k, int off);
    longint base;
    base = (longint'(k) * HALF_TURN) >>> (Q56_FRAC - tsc_pkg::ANGLE_FRAC);
    return 32'(base + off);
  endfunction

  function automatic logic signed [31:0] random_angle();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5)
      return $urandom;
    else if (kind < 7)
      return near_pi_multiple(int'($urandom_range(0, 10)) - 5,
                              int'($urandom_range(0, 64)) - 32);
    else if (kind < 9)
      return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    // around plus or minus pi/2, where the sine sum sits close to plus or minus one
    return near_pi_multiple(int'($urandom_range(0, 1)) * 2 - 1, 0) / 2
           + (int'($urandom_range(0, 2048)) - 1024);
  endfunction

  task automatic test_corner_angles();
    logic signed [31:0] corner_angles[$];
    corner_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh0800_0000, -32'sh0800_0000, 32'sh5555_5555, 32'shAAAA_AAAA};
    // just inside and just beyond pi, 3pi and 5pi, and twice just beyond their negatives
    for (int k = 1; k <= 5; k += 2) begin
      corner_angles.push_back(near_pi_multiple(k, 0));
      corner_angles.push_back(near_pi_multiple(k, 1));
      corner_angles.push_back(near_pi_multiple(-k, 0));
      corner_angles.push_back(near_pi_multiple(-k, -1));
    end
    corner_angles.push_back(near_pi_multiple(1, 0) / 2);
    corner_angles.push_back(-(near_pi_multiple(1, 0) / 2));
    foreach (corner_angles[i])
      send_angle(corner_angles[i]);
  endtask

  task automatic test_random_angles(int count, bit with_gaps);
    for (int i = 0; i < count; i++) begin
      if (with_gaps)
        maybe_pause();
      send_angle(random_angle());
    end
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (expected_sincos.size() != 0)
      @(posedge clk);
    test_random_angles(10, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sincos_t want;
      results_seen++;
      if (expected_sincos.size() == 0) begin
        report($sformatf("result with none pending: sine %h cosine %h",
                         out_sine, out_cosine));
      end else begin
        want = expected_sincos.pop_front();
        if (out_sine !== want.sine)
          report($sformatf("angle %h sine got %h expected %h",
                           want.angle, out_sine, want.sine));
        if (out_cosine !== want.cosine)
          report($sformatf("angle %h cosine got %h expected %h",
                           want.angle, out_cosine, want.cosine));
      end
    end
  end

  initial begin
    #2ms;
    $display("taylor_sine_cosine_top verification failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_angles();
    test_random_angles(200, 1'b1);
    test_random_angles(150, 1'b0);
    test_drain_pause();
    test_random_angles(200, 1'b1);
    start <= 1'b0;
    while (expected_sincos.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    $display("covered %0d angles: corners, pi multiples, full-range and small random",
             angles_sent);
    $display("back-to-back stream and a full drain; %0d results checked, %0d mismatches",
             results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_sincos.size() == 0)
      $display("taylor_sine_cosine_top verification clean");
    else
      $display("taylor_sine_cosine_top verification failed");
    $finish;
  end

endmodule

/* files.f */
hdl/tsc_pkg.sv
hdl/tsc_mul.sv
hdl/tsc_cell.sv
hdl/taylor_sine_cosine_top.sv
hdl/tsc_checker.sv
bench/testbench.sv
